### src/setei_pkg.sv
package setei_pkg;

   localparam int NODE_BITS   = 10;
   localparam int WEIGHT_BITS = 32;
   localparam int DEG_BITS    = 12;
   localparam int CNT_BITS    = 11;
   localparam int TOTAL_BITS  = 11;

   localparam logic [DEG_BITS-1:0] DEG_MAX = '1;
   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

   localparam logic [1:0] MODE_INSERT    = 2'd0;
   localparam logic [1:0] MODE_READ_EDGE = 2'd1;
   localparam logic [1:0] MODE_READ_NODE = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef enum logic [1:0] {
      K_INSERT,
      K_READ_EDGE,
      K_READ_NODE,
      K_ERROR
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [NODE_BITS-1:0]    src;
      logic [NODE_BITS-1:0]    dst;
      logic [WEIGHT_BITS-1:0]  weight;
      logic [NODE_BITS-1:0]    ridx;
   } cmd_type;

   typedef struct packed {
      logic [NODE_BITS-1:0]    src;
      logic [NODE_BITS-1:0]    dst;
      logic [WEIGHT_BITS-1:0]  weight;
   } edge_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EDGE_DATA,
      S_NODE_DATA,
      S_SRC_DATA,
      S_DST_DATA,
      S_SHIFT_RD,
      S_SHIFT_CMP
   } state_type;

endpackage

### src/setei_front.sv
module setei_front
   import setei_pkg::*;
#(
   parameter int NODE_LIMIT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_mode,
   input  logic [NODE_BITS-1:0]   req_source_node,
   input  logic [NODE_BITS-1:0]   req_target_node,
   input  logic [WEIGHT_BITS-1:0] req_weight_bits,
   input  logic [NODE_BITS-1:0]   req_read_index,
   input  back_ctl_type           ctl,
   output cmd_type                head,
   output logic                   head_valid
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   cmd_type    cmd;
   logic       push, pop;

   assign busy       = (cnt_ff == 2'd2) || ctl.clearing;
   assign push       = start && !busy;
   assign pop        = ctl.pop && (cnt_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (cnt_ff != 2'd0);

   // range checks that do not depend on the table fill
   always_comb begin
      cmd.src    = req_source_node;
      cmd.dst    = req_target_node;
      cmd.weight = req_weight_bits;
      cmd.ridx   = req_read_index;
      unique case (req_mode)
         MODE_INSERT: begin
            if (32'(req_source_node) >= 32'(NODE_LIMIT) ||
                32'(req_target_node) >= 32'(NODE_LIMIT))
               cmd.kind = K_ERROR;
            else
               cmd.kind = K_INSERT;
         end
         MODE_READ_EDGE: cmd.kind = K_READ_EDGE;
         MODE_READ_NODE: begin
            if (32'(req_read_index) >= 32'(NODE_LIMIT)) cmd.kind = K_ERROR;
            else cmd.kind = K_READ_NODE;
         end
         default: cmd.kind = K_ERROR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cmd;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

### src/setei_back.sv
module setei_back
   import setei_pkg::*;
#(
   parameter int EDGE_CAPACITY = 1024,
   parameter int NODE_LIMIT    = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                head,
   input  logic                   head_valid,
   output back_ctl_type           ctl,
   output logic                   strobe,
   output logic [1:0]             rsp_status,
   output logic [NODE_BITS-1:0]   rsp_slot,
   output logic [NODE_BITS-1:0]   rsp_entry_source,
   output logic [NODE_BITS-1:0]   rsp_entry_target,
   output logic [WEIGHT_BITS-1:0] rsp_entry_weight,
   output logic [DEG_BITS-1:0]    rsp_node_degree_value,
   output logic [CNT_BITS-1:0]    rsp_node_source_count,
   output logic [TOTAL_BITS-1:0]  rsp_edge_total
);

   localparam int EW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
   localparam int FW = $clog2(EDGE_CAPACITY + 1);
   localparam int NW = (NODE_LIMIT > 1) ? $clog2(NODE_LIMIT) : 1;

   edge_type            edge_mem [EDGE_CAPACITY];
   logic [DEG_BITS-1:0] deg_mem  [NODE_LIMIT];
   logic [CNT_BITS-1:0] cnt_mem  [NODE_LIMIT];

   state_type            state_ff, state_in;
   cmd_type              cur_ff, cur_in;
   logic [FW-1:0]        fill_ff, fill_in, k_ff, k_in;
   logic [NW-1:0]        clr_ff, clr_in;
   logic [DEG_BITS-1:0]  deg_src_ff, deg_src_in;
   logic [CNT_BITS-1:0]  cnt_src_ff, cnt_src_in;
   logic [NODE_BITS-1:0] ins_src_ff, ins_src_in, ins_dst_ff, ins_dst_in;

   edge_type             edge_rd_ff, edge_wdata;
   logic [DEG_BITS-1:0]  deg_rd_ff, deg_wdata;
   logic [CNT_BITS-1:0]  cnt_rd_ff, cnt_wdata;
   logic [EW-1:0]        edge_raddr, edge_waddr;
   logic [NW-1:0]        node_raddr, deg_waddr, cnt_waddr;
   logic                 edge_we, deg_we, cnt_we;

   logic                 strobe_in;
   logic [1:0]           status_in;
   logic [NODE_BITS-1:0] slot_in, esrc_in, edst_in;
   logic [WEIGHT_BITS-1:0] ew_in;
   logic [DEG_BITS-1:0]  deg_out_in;
   logic [CNT_BITS-1:0]  cnt_out_in;
   logic [TOTAL_BITS-1:0] total_in;

   logic                 full, edge_oob, entry_below, swap;
   logic [DEG_BITS-1:0]  deg_base;
   logic [CNT_BITS-1:0]  cnt_new;

   assign full     = (32'(fill_ff) >= 32'(EDGE_CAPACITY));
   assign edge_oob = (32'(head.ridx) >= 32'(fill_ff));
   assign entry_below = (edge_rd_ff.src < ins_src_ff) ||
                        (edge_rd_ff.src == ins_src_ff && edge_rd_ff.dst < ins_dst_ff);
   // self loop sees the degree already bumped for the source
   assign deg_base = (cur_ff.src == cur_ff.dst) ? deg_src_ff : deg_rd_ff;
   assign swap     = cnt_src_ff > cnt_rd_ff;
   assign cnt_new  = swap ? cnt_rd_ff : cnt_src_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == NW'(NODE_LIMIT - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (head_valid) begin
               unique case (head.kind)
                  K_INSERT:    state_in = full ? S_IDLE : S_SRC_DATA;
                  K_READ_EDGE: state_in = edge_oob ? S_IDLE : S_EDGE_DATA;
                  K_READ_NODE: state_in = S_NODE_DATA;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_EDGE_DATA: state_in = S_IDLE;
         S_NODE_DATA: state_in = S_IDLE;
         S_SRC_DATA:  state_in = S_DST_DATA;
         S_DST_DATA:  state_in = S_SHIFT_RD;
         S_SHIFT_RD:  state_in = (k_ff == '0) ? S_IDLE : S_SHIFT_CMP;
         S_SHIFT_CMP: state_in = entry_below ? S_IDLE : S_SHIFT_RD;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl.pop      = 1'b0;
      ctl.clearing = (state_ff == S_CLEAR);
      cur_in     = cur_ff;
      fill_in    = fill_ff;
      k_in       = k_ff;
      clr_in     = clr_ff;
      deg_src_in = deg_src_ff;
      cnt_src_in = cnt_src_ff;
      ins_src_in = ins_src_ff;
      ins_dst_in = ins_dst_ff;
      edge_raddr = EW'(head.ridx);
      edge_we    = 1'b0;
      edge_waddr = EW'(k_ff);
      edge_wdata = edge_rd_ff;
      node_raddr = NW'(head.ridx);
      deg_we     = 1'b0;
      deg_waddr  = NW'(cur_ff.src);
      deg_wdata  = '0;
      cnt_we     = 1'b0;
      cnt_waddr  = clr_ff;
      cnt_wdata  = '0;
      strobe_in  = 1'b0;
      status_in  = ST_OK;
      slot_in    = '0;
      esrc_in    = '0;
      edst_in    = '0;
      ew_in      = '0;
      deg_out_in = '0;
      cnt_out_in = '0;
      total_in   = TOTAL_BITS'(fill_ff);
      unique case (state_ff)
         S_CLEAR: begin
            deg_we    = 1'b1;
            deg_waddr = clr_ff;
            cnt_we    = 1'b1;
            clr_in    = clr_ff + NW'(1);
         end
         S_IDLE: begin
            if (head_valid) begin
               ctl.pop = 1'b1;
               cur_in  = head;
               unique case (head.kind)
                  K_INSERT: begin
                     node_raddr = NW'(head.src);
                     if (full) begin
                        strobe_in = 1'b1;
                        status_in = ST_FULL;
                     end
                  end
                  K_READ_EDGE: begin
                     if (edge_oob) begin
                        strobe_in = 1'b1;
                        status_in = ST_RANGE;
                     end
                  end
                  K_READ_NODE: ;
                  default: begin
                     strobe_in = 1'b1;
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_EDGE_DATA: begin
            strobe_in = 1'b1;
            esrc_in   = edge_rd_ff.src;
            edst_in   = edge_rd_ff.dst;
            ew_in     = edge_rd_ff.weight;
         end
         S_NODE_DATA: begin
            strobe_in  = 1'b1;
            deg_out_in = deg_rd_ff;
            cnt_out_in = cnt_rd_ff;
         end
         S_SRC_DATA: begin
            deg_src_in = (deg_rd_ff < DEG_MAX) ? deg_rd_ff + 1'b1 : deg_rd_ff;
            cnt_src_in = cnt_rd_ff;
            deg_we     = 1'b1;
            deg_waddr  = NW'(cur_ff.src);
            deg_wdata  = deg_src_in;
            node_raddr = NW'(cur_ff.dst);
         end
         S_DST_DATA: begin
            deg_we     = 1'b1;
            deg_waddr  = NW'(cur_ff.dst);
            deg_wdata  = (deg_base < DEG_MAX) ? deg_base + 1'b1 : deg_base;
            ins_src_in = swap ? cur_ff.dst : cur_ff.src;
            ins_dst_in = swap ? cur_ff.src : cur_ff.dst;
            cnt_we     = 1'b1;
            cnt_waddr  = NW'(ins_src_in);
            cnt_wdata  = (cnt_new < CNT_MAX) ? cnt_new + 1'b1 : cnt_new;
            k_in       = fill_ff;
         end
         S_SHIFT_RD: begin
            edge_raddr = EW'(k_ff - FW'(1));
            if (k_ff == '0) begin
               edge_we    = 1'b1;
               edge_wdata = '{src: ins_src_ff, dst: ins_dst_ff, weight: cur_ff.weight};
            end
         end
         S_SHIFT_CMP: begin
            edge_we = 1'b1;
            if (entry_below) begin
               edge_wdata = '{src: ins_src_ff, dst: ins_dst_ff, weight: cur_ff.weight};
            end else begin
               edge_wdata = edge_rd_ff;
               k_in       = k_ff - FW'(1);
            end
         end
         default: ;
      endcase
      // finishing beat of an insert
      if ((state_ff == S_SHIFT_RD && k_ff == '0) ||
          (state_ff == S_SHIFT_CMP && entry_below)) begin
         fill_in   = fill_ff + FW'(1);
         strobe_in = 1'b1;
         slot_in   = NODE_BITS'(k_ff);
         esrc_in   = ins_src_ff;
         edst_in   = ins_dst_ff;
         ew_in     = cur_ff.weight;
         total_in  = TOTAL_BITS'(fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
      edge_rd_ff <= edge_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      deg_rd_ff <= deg_mem[node_raddr];
      cnt_rd_ff <= cnt_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      k_ff       <= k_in;
      deg_src_ff <= deg_src_in;
      cnt_src_ff <= cnt_src_in;
      ins_src_ff <= ins_src_in;
      ins_dst_ff <= ins_dst_in;
      rsp_status            <= status_in;
      rsp_slot              <= slot_in;
      rsp_entry_source      <= esrc_in;
      rsp_entry_target      <= edst_in;
      rsp_entry_weight      <= ew_in;
      rsp_node_degree_value <= deg_out_in;
      rsp_node_source_count <= cnt_out_in;
      rsp_edge_total        <= total_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         fill_ff  <= '0;
         clr_ff   <= '0;
         strobe   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         clr_ff   <= clr_in;
         strobe   <= strobe_in;
      end
   end

endmodule

### src/sorted_edge_table_insert.sv
// channel    | handshake           | beat
// request    | start / busy        | req_mode, req_source_node, req_target_node,
//            |                     | req_weight_bits, req_read_index
// response   | strobe (no backoff) | rsp_status .. rsp_edge_total
//
// reads and errors each answer with a single strobe; an insert moves every entry that sorts
// after it up one slot, walking backward through the edge memory from the end
// after reset busy stays high while the node counters
// are zeroed; a two-beat queue lets requests land while the back end works
// the response side cannot stall, each result shows for one cycle
module sorted_edge_table_insert
   import setei_pkg::*;
#(
   parameter int EDGE_CAPACITY = 1024,
   parameter int NODE_LIMIT    = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_mode,
   input  logic [NODE_BITS-1:0]   req_source_node,
   input  logic [NODE_BITS-1:0]   req_target_node,
   input  logic [WEIGHT_BITS-1:0] req_weight_bits,
   input  logic [NODE_BITS-1:0]   req_read_index,
   output logic                   strobe,
   output logic [1:0]             rsp_status,
   output logic [NODE_BITS-1:0]   rsp_slot,
   output logic [NODE_BITS-1:0]   rsp_entry_source,
   output logic [NODE_BITS-1:0]   rsp_entry_target,
   output logic [WEIGHT_BITS-1:0] rsp_entry_weight,
   output logic [DEG_BITS-1:0]    rsp_node_degree_value,
   output logic [CNT_BITS-1:0]    rsp_node_source_count,
   output logic [TOTAL_BITS-1:0]  rsp_edge_total
);

   cmd_type      head;
   logic         head_valid;
   back_ctl_type ctl;

   setei_front #(.NODE_LIMIT(NODE_LIMIT)) u_front (
      .clock, .reset, .start, .busy,
      .req_mode, .req_source_node, .req_target_node, .req_weight_bits, .req_read_index,
      .ctl, .head, .head_valid
   );

   setei_back #(.EDGE_CAPACITY(EDGE_CAPACITY), .NODE_LIMIT(NODE_LIMIT)) u_back (
      .clock, .reset, .head, .head_valid, .ctl, .strobe,
      .rsp_status, .rsp_slot, .rsp_entry_source, .rsp_entry_target, .rsp_entry_weight,
      .rsp_node_degree_value, .rsp_node_source_count, .rsp_edge_total
   );

endmodule

### test/setei_checker.sv
`timescale 1ns / 100ps

module setei_checker
   import setei_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [1:0]             req_mode,
   input  logic [NODE_BITS-1:0]   req_source_node,
   input  logic [NODE_BITS-1:0]   req_target_node,
   input  logic [WEIGHT_BITS-1:0] req_weight_bits,
   input  logic [NODE_BITS-1:0]   req_read_index,
   input  logic                   strobe,
   input  logic [1:0]             rsp_status,
   input  logic [NODE_BITS-1:0]   rsp_slot,
   input  logic [NODE_BITS-1:0]   rsp_entry_source,
   input  logic [NODE_BITS-1:0]   rsp_entry_target,
   input  logic [WEIGHT_BITS-1:0] rsp_entry_weight,
   input  logic [DEG_BITS-1:0]    rsp_node_degree_value,
   input  logic [CNT_BITS-1:0]    rsp_node_source_count,
   input  logic [TOTAL_BITS-1:0]  rsp_edge_total,
   output int                     fail_count,
   output int                     pending
);

   localparam int EDGE_CAPACITY = 1024;
   localparam int NODE_LIMIT    = 1024;

   typedef struct {
      logic [1:0]             status;
      logic [NODE_BITS-1:0]   slot;
      logic [NODE_BITS-1:0]   esrc;
      logic [NODE_BITS-1:0]   edst;
      logic [WEIGHT_BITS-1:0] ewt;
      logic [DEG_BITS-1:0]    degree;
      logic [CNT_BITS-1:0]    src_count;
      logic [TOTAL_BITS-1:0]  total;
   } table_rsp_type;

   logic [NODE_BITS-1:0]   tab_src [EDGE_CAPACITY];
   logic [NODE_BITS-1:0]   tab_dst [EDGE_CAPACITY];
   logic [WEIGHT_BITS-1:0] tab_wt  [EDGE_CAPACITY];
   logic [DEG_BITS-1:0]    node_deg [NODE_LIMIT];
   logic [CNT_BITS-1:0]    node_src_cnt [NODE_LIMIT];
   int                     edge_count;
   table_rsp_type          expected_rsp [$];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic table_rsp_type table_step(input logic [1:0] mode,
                                                input logic [NODE_BITS-1:0] s_in,
                                                input logic [NODE_BITS-1:0] t_in,
                                                input logic [WEIGHT_BITS-1:0] w,
                                                input logic [NODE_BITS-1:0] ridx);
      table_rsp_type r;
      logic [NODE_BITS-1:0] s, t, tmp;
      int pos;
      r = '{default: '0};
      r.status = ST_RANGE;
      s = s_in;
      t = t_in;
      if (mode == MODE_INSERT) begin
         if (s >= NODE_LIMIT || t >= NODE_LIMIT) begin
            r.status = ST_RANGE;
         end else if (edge_count >= EDGE_CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            if (node_deg[s] != DEG_MAX) node_deg[s]++;
            if (node_deg[t] != DEG_MAX) node_deg[t]++;
            if (node_src_cnt[s] > node_src_cnt[t]) begin
               tmp = s;
               s = t;
               t = tmp;
            end
            pos = edge_count;
            for (int k = 0; k < edge_count; k++) begin
               if (tab_src[k] > s || (tab_src[k] == s && tab_dst[k] >= t)) begin
                  pos = k;
                  break;
               end
            end
            for (int k = edge_count; k > pos; k--) begin
               tab_src[k] = tab_src[k-1];
               tab_dst[k] = tab_dst[k-1];
               tab_wt[k]  = tab_wt[k-1];
            end
            tab_src[pos] = s;
            tab_dst[pos] = t;
            tab_wt[pos]  = w;
            edge_count++;
            if (node_src_cnt[s] != CNT_MAX) node_src_cnt[s]++;
            r.status = ST_OK;
            r.slot   = pos[NODE_BITS-1:0];
            r.esrc   = s;
            r.edst   = t;
            r.ewt    = w;
         end
      end else if (mode == MODE_READ_EDGE) begin
         if (ridx < edge_count) begin
            r.status = ST_OK;
            r.esrc   = tab_src[ridx];
            r.edst   = tab_dst[ridx];
            r.ewt    = tab_wt[ridx];
         end
      end else if (mode == MODE_READ_NODE) begin
         if (ridx < NODE_LIMIT) begin
            r.status    = ST_OK;
            r.degree    = node_deg[ridx];
            r.src_count = node_src_cnt[ridx];
         end
      end
      r.total = edge_count[TOTAL_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      table_rsp_type want;
      if (reset) begin
         for (int n = 0; n < NODE_LIMIT; n++) begin
            node_deg[n]     = '0;
            node_src_cnt[n] = '0;
         end
         edge_count = 0;
         expected_rsp.delete();
      end else begin
         if (strobe) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected beat", {30'd0, rsp_status}, 32'd0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_status !== want.status)
                  report("status", 32'(rsp_status), 32'(want.status));
               if (rsp_slot !== want.slot)
                  report("slot", 32'(rsp_slot), 32'(want.slot));
               if (rsp_entry_source !== want.esrc)
                  report("entry_source", 32'(rsp_entry_source), 32'(want.esrc));
               if (rsp_entry_target !== want.edst)
                  report("entry_target", 32'(rsp_entry_target), 32'(want.edst));
               if (rsp_entry_weight !== want.ewt)
                  report("entry_weight", rsp_entry_weight, want.ewt);
               if (rsp_node_degree_value !== want.degree)
                  report("node_degree_value", 32'(rsp_node_degree_value),
                         32'(want.degree));
               if (rsp_node_source_count !== want.src_count)
                  report("node_source_count", 32'(rsp_node_source_count),
                         32'(want.src_count));
               if (rsp_edge_total !== want.total)
                  report("edge_total", 32'(rsp_edge_total), 32'(want.total));
            end
         end
         if (start && !busy) begin
            want = table_step(req_mode, req_source_node, req_target_node,
                              req_weight_bits, req_read_index);
            expected_rsp = {expected_rsp, want};
         end
      end
      pending <= expected_rsp.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end

endmodule

### test/tb_sorted_edge_table_insert.sv
`timescale 1ns / 100ps

module tb_sorted_edge_table_insert;
   import setei_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [1:0]             req_mode;
   logic [NODE_BITS-1:0]   req_source_node;
   logic [NODE_BITS-1:0]   req_target_node;
   logic [WEIGHT_BITS-1:0] req_weight_bits;
   logic [NODE_BITS-1:0]   req_read_index;
   logic                   strobe;
   logic [1:0]             rsp_status;
   logic [NODE_BITS-1:0]   rsp_slot;
   logic [NODE_BITS-1:0]   rsp_entry_source;
   logic [NODE_BITS-1:0]   rsp_entry_target;
   logic [WEIGHT_BITS-1:0] rsp_entry_weight;
   logic [DEG_BITS-1:0]    rsp_node_degree_value;
   logic [CNT_BITS-1:0]    rsp_node_source_count;
   logic [TOTAL_BITS-1:0]  rsp_edge_total;
   int                     fail_count;
   int                     pending;
   int                     inserts_sent;
   bit                     allow_gaps;

   sorted_edge_table_insert u_top (.*);

   setei_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("FAIL");
      $finish;
   end

   // drive one beat and hold it until the block takes it
   task automatic send_cmd(input logic [1:0] m, input logic [NODE_BITS-1:0] s,
                           input logic [NODE_BITS-1:0] t, input logic [WEIGHT_BITS-1:0] w,
                           input logic [NODE_BITS-1:0] r);
      if (allow_gaps && $urandom_range(99) < 21) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= m;
      req_source_node <= s;
      req_target_node <= t;
      req_weight_bits <= w;
      req_read_index  <= r;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      if (m == MODE_INSERT) inserts_sent++;
   endtask

   function automatic logic [NODE_BITS-1:0] pick_node();
      return ($urandom_range(1)) ? NODE_BITS'($urandom_range(0, 15))
                                 : NODE_BITS'($urandom_range(0, 1023));
   endfunction

   initial begin
      logic [NODE_BITS-1:0] rd;
      int pick;
      start           <= 1'b0;
      req_mode        <= MODE_INSERT;
      req_source_node <= '0;
      req_target_node <= '0;
      req_weight_bits <= '0;
      req_read_index  <= '0;
      reset           <= 1'b1;
      inserts_sent = 0;
      allow_gaps   = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, self loop, swap, equal edges, bad mode
      send_cmd(MODE_READ_EDGE, 0, 0, 0, 0);
      send_cmd(MODE_READ_NODE, 0, 0, 0, 0);
      send_cmd(MODE_READ_NODE, 0, 0, 0, 1023);
      send_cmd(MODE_UNUSED, 1023, 1023, '1, 1023);
      send_cmd(MODE_INSERT, 0, 0, 32'h0, 0);
      send_cmd(MODE_INSERT, 1023, 1023, 32'hffff_ffff, 1023);
      send_cmd(MODE_INSERT, 5, 5, 32'h5555_aaaa, 0);
      send_cmd(MODE_INSERT, 5, 9, 32'h0000_0009, 0);
      send_cmd(MODE_INSERT, 5, 9, 32'h0000_0010, 0);
      send_cmd(MODE_INSERT, 9, 5, 32'haaaa_5555, 0);
      send_cmd(MODE_INSERT, 1023, 0, 32'h1234_5678, 0);
      send_cmd(MODE_READ_NODE, 0, 0, 0, 5);
      send_cmd(MODE_READ_NODE, 0, 0, 0, 1023);
      for (int i = 0; i < 8; i++) send_cmd(MODE_READ_EDGE, 0, 0, 0, NODE_BITS'(i));
      send_cmd(MODE_READ_EDGE, 0, 0, 0, 1023);

      for (int i = 0; i < 920; i++) begin
         allow_gaps = !(i >= 300 && i < 500);
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_cmd(MODE_INSERT, pick_node(), pick_node(), $urandom, NODE_BITS'($urandom));
         end else if (pick < 70) begin
            rd = ($urandom_range(9) == 0) ? NODE_BITS'($urandom)
                 : NODE_BITS'($urandom_range(0, inserts_sent + 2));
            send_cmd(MODE_READ_EDGE, NODE_BITS'($urandom), NODE_BITS'($urandom),
                     $urandom, rd);
         end else if (pick < 95) begin
            rd = ($urandom_range(1)) ? NODE_BITS'($urandom_range(0, 15)) : NODE_BITS'($urandom);
            send_cmd(MODE_READ_NODE, NODE_BITS'($urandom), NODE_BITS'($urandom),
                     $urandom, rd);
         end else begin
            send_cmd(MODE_UNUSED, NODE_BITS'($urandom), NODE_BITS'($urandom), $urandom,
                     NODE_BITS'($urandom));
         end
      end

      allow_gaps = 1'b1;
      send_cmd(MODE_READ_EDGE, 0, 0, 0, 1023);
      send_cmd(MODE_READ_EDGE, 0, 0, 0, 0);
      send_cmd(MODE_READ_NODE, 0, 0, 0, 1023);
      send_cmd(MODE_UNUSED, 0, 0, 0, 0);

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
